>>> sv/assert_macros.svh
// assertion macros shared by the dense layer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ANY(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ANY(lbl, clk, prop, msg)
`endif
`endif

>>> sv/dlr_pkg.sv
// types and constants of the dense layer core
`default_nettype none
package dlr_pkg;

	localparam int VAL_W    = 16;
	localparam int FRAC_W   = 12;
	localparam int ACC_W    = 40;
	localparam int PROD_W   = 2 * VAL_W;
	localparam int SUM_W    = ACC_W + 2;
	localparam int IDX_W    = 12;
	localparam int ICNT_W   = 11;
	localparam int OCNT_W   = 13;
	localparam int CFG_W    = OCNT_W;
	localparam int CFGI_W   = 2;
	localparam int MAX_OUTS = 4096;

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = 3;
	localparam int FIFO_CNT_W = 4;

	localparam logic [ICNT_W-1:0] ICNT_RESET = ICNT_W'(64);
	localparam logic [OCNT_W-1:0] OCNT_RESET = OCNT_W'(64);

	localparam logic [CFGI_W-1:0] CFG_INPUT_COUNT  = 2'd0;
	localparam logic [CFGI_W-1:0] CFG_OUTPUT_COUNT = 2'd1;
	localparam logic [CFGI_W-1:0] CFG_RELU_ENABLE  = 2'd2;

	localparam logic KIND_ACT    = 1'b0;
	localparam logic KIND_WEIGHT = 1'b1;

	typedef struct packed {
		logic                    kind;
		logic signed [VAL_W-1:0] sample;
		logic signed [VAL_W-1:0] bias_value;
	} in_word_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] neuron_value;
		logic [IDX_W-1:0]        neuron_index;
		logic                    last_neuron;
	} out_word_t;

	// weight word handed from the issue logic to the mac pipeline
	typedef struct packed {
		logic                    valid;
		logic                    row_end;
		logic                    last_neuron;
		logic [IDX_W-1:0]        neuron_index;
		logic signed [VAL_W-1:0] sample;
		logic signed [VAL_W-1:0] bias_value;
	} mac_issue_t;

endpackage
`default_nettype wire

>>> sv/dlr_act_mem.sv
// activation memory, one write and one registered read port
`default_nettype none
module dlr_act_mem #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10
) (
	input  wire logic                           clk,
	input  wire logic                           we,
	input  wire logic [ADDR_W-1:0]              waddr,
	input  wire logic signed [dlr_pkg::VAL_W-1:0] wdata,
	input  wire logic                           re,
	input  wire logic [ADDR_W-1:0]              raddr,
	output logic signed [dlr_pkg::VAL_W-1:0]      rdata
);
	import dlr_pkg::*;

	logic signed [VAL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> sv/dlr_mac.sv
// multiply, accumulate and finish pipeline of the dense layer
`default_nettype none
`include "assert_macros.svh"
module dlr_mac (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             relu_en,
	input  wire dlr_pkg::mac_issue_t              issue,
	input  wire logic signed [dlr_pkg::VAL_W-1:0] act,
	output logic                                  push,
	output dlr_pkg::out_word_t                    push_word
);
	import dlr_pkg::*;

	localparam int Q_W = SUM_W - FRAC_W;
	localparam logic signed [SUM_W-1:0] ROUND_C = SUM_W'(1) << (FRAC_W - 1);

	logic                    v_s1, v_s2, v_s3;
	logic                    end_s1, end_s2;
	logic                    last_s1, last_s2, last_s3;
	logic [IDX_W-1:0]        idx_s1, idx_s2, idx_s3;
	logic signed [VAL_W-1:0] smp_s1;
	logic signed [VAL_W-1:0] bias_s1, bias_s2, bias_s3;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0] fin_s3;
	logic signed [ACC_W-1:0] acc_q;

	logic signed [ACC_W:0]   acc_sum;
	logic signed [ACC_W-1:0] acc_sat;
	logic signed [SUM_W-1:0] fin_x, bias_x, total;
	logic [Q_W-1:0]          q_raw, q_relu;
	logic signed [VAL_W-1:0] q_sat;

	// saturating accumulate
	always_comb begin
		acc_sum = {{(ACC_W + 1 - PROD_W){prod_s2[PROD_W-1]}}, prod_s2} +
			{acc_q[ACC_W-1], acc_q};
		if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
			acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			acc_sat = acc_sum[ACC_W-1:0];
		end
	end

	// bias, round half up, relu, saturate to the value range
	always_comb begin
		fin_x  = {{(SUM_W-ACC_W){fin_s3[ACC_W-1]}}, fin_s3};
		bias_x = {{(SUM_W-VAL_W-FRAC_W){bias_s3[VAL_W-1]}}, bias_s3, {FRAC_W{1'b0}}};
		total  = fin_x + bias_x + ROUND_C;
		q_raw  = total[SUM_W-1:FRAC_W];
		q_relu = (relu_en && q_raw[Q_W-1]) ? '0 : q_raw;
		if (!q_relu[Q_W-1] && (|q_relu[Q_W-2:VAL_W-1])) begin
			q_sat = {1'b0, {(VAL_W-1){1'b1}}};
		end else if (q_relu[Q_W-1] && !(&q_relu[Q_W-2:VAL_W-1])) begin
			q_sat = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			q_sat = q_relu[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			acc_q <= '0;
		end else begin
			v_s1 <= issue.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && end_s2;
			if (v_s2) begin
				acc_q <= end_s2 ? '0 : acc_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		end_s1  <= issue.row_end;
		last_s1 <= issue.last_neuron;
		idx_s1  <= issue.neuron_index;
		smp_s1  <= issue.sample;
		bias_s1 <= issue.bias_value;

		prod_s2 <= act * smp_s1;
		end_s2  <= end_s1;
		last_s2 <= last_s1;
		idx_s2  <= idx_s1;
		bias_s2 <= bias_s1;

		fin_s3  <= acc_sat;
		last_s3 <= last_s2;
		idx_s3  <= idx_s2;
		bias_s3 <= bias_s2;
	end

	assign push                   = v_s3;
	assign push_word.neuron_value = q_sat;
	assign push_word.neuron_index = idx_s3;
	assign push_word.last_neuron  = last_s3;

	`ASSERT_RST(a_row_end_pushes, clk, arst_n, (v_s1 && end_s1) |-> ##2 push, "row end lost")
	`ASSERT_RST(a_acc_cleared, clk, arst_n, v_s3 |-> (acc_q == '0), "accumulator not cleared")
	`ASSERT_RST(a_relu_sign, clk, arst_n, (push && relu_en) |-> !push_word.neuron_value[VAL_W-1],
		"negative result with relu")

endmodule
`default_nettype wire

>>> sv/dlr_out_fifo.sv
// result queue between the mac pipeline and the output channel
`default_nettype none
`include "assert_macros.svh"
module dlr_out_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire dlr_pkg::out_word_t push_word,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output dlr_pkg::out_word_t      out_word
);
	import dlr_pkg::*;

	out_word_t             mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_q, rd_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_word  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_word;
		end
	end

	`ASSERT_RST(a_no_overflow, clk, arst_n, (count_q == FIFO_CNT_W'(FIFO_DEPTH)) |-> !push,
		"result queue overflow")
	`ASSERT_RST(a_count_up, clk, arst_n, (push && !pop) |=> (count_q == $past(count_q) + 1'b1),
		"queue count did not rise")
	`ASSERT_RST(a_count_down, clk, arst_n, (!push && pop) |=> (count_q == $past(count_q) - 1'b1),
		"queue count did not fall")

endmodule
`default_nettype wire

>>> sv/dense_layer_forward_relu_core.sv
// fully connected layer with relu: issue counters, activation memory, mac, result queue
// a row's last weight word goes through mac stages s1, s2, s3 into the result queue
// one input word per cycle while in_ready is high; single mac, one memory read per weight
// in_ready drops only while 8 result words are queued or in flight (credit counter)
// reset clears counters, accumulator, queue and sets config to 64 / 64 / relu off
// the activation memory is not cleared; a slot must be loaded before a weight reads it
`default_nettype none
module dense_layer_forward_relu_core #(
	parameter int MAX_INPUTS = 1024
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [dlr_pkg::CFGI_W-1:0]  cfg_index,
	input  wire logic [dlr_pkg::CFG_W-1:0]   cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire dlr_pkg::in_word_t           in_word,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output dlr_pkg::out_word_t               out_word
);
	import dlr_pkg::*;

	localparam int ADDR_W = $clog2(MAX_INPUTS);
	localparam int NW     = $clog2(MAX_INPUTS + 1);
	localparam int CNT_W  = (NW > ICNT_W) ? NW : ICNT_W;

	logic [ICNT_W-1:0]     input_count_q;
	logic [OCNT_W-1:0]     output_count_q;
	logic                  relu_q;
	logic [ADDR_W-1:0]     slot_q, wpos_q;
	logic [IDX_W-1:0]      neuron_q;
	logic [FIFO_CNT_W-1:0] cred_q;

	logic [CNT_W-1:0]        n_eff;
	logic [OCNT_W-1:0]       m_eff;
	logic                    fire, act_wr, w_fire, pop;
	logic                    slot_last, row_last, layer_last;
	mac_issue_t              issue;
	logic signed [VAL_W-1:0] act;
	logic                    push;
	out_word_t               push_word;

	// clamp the count registers to their usable ranges
	always_comb begin
		if (input_count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (CNT_W'(input_count_q) > CNT_W'(MAX_INPUTS)) begin
			n_eff = CNT_W'(MAX_INPUTS);
		end else begin
			n_eff = CNT_W'(input_count_q);
		end
		if (output_count_q == '0) begin
			m_eff = OCNT_W'(1);
		end else if (output_count_q > OCNT_W'(MAX_OUTS)) begin
			m_eff = OCNT_W'(MAX_OUTS);
		end else begin
			m_eff = output_count_q;
		end
	end

	assign in_ready   = (cred_q != FIFO_CNT_W'(FIFO_DEPTH));
	assign fire       = in_valid && in_ready;
	assign act_wr     = fire && (in_word.kind == KIND_ACT);
	assign w_fire     = fire && (in_word.kind == KIND_WEIGHT);
	assign pop        = out_valid && out_ready;
	assign slot_last  = (CNT_W'(slot_q) + CNT_W'(1)) >= n_eff;
	assign row_last   = (CNT_W'(wpos_q) + CNT_W'(1)) >= n_eff;
	assign layer_last = ({1'b0, neuron_q} + OCNT_W'(1)) >= m_eff;

	assign issue.valid        = w_fire;
	assign issue.row_end      = row_last;
	assign issue.last_neuron  = layer_last;
	assign issue.neuron_index = neuron_q;
	assign issue.sample       = in_word.sample;
	assign issue.bias_value   = in_word.bias_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_count_q  <= ICNT_RESET;
			output_count_q <= OCNT_RESET;
			relu_q         <= 1'b0;
			slot_q         <= '0;
			wpos_q         <= '0;
			neuron_q       <= '0;
			cred_q         <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_INPUT_COUNT:  input_count_q  <= cfg_data[ICNT_W-1:0];
					CFG_OUTPUT_COUNT: output_count_q <= cfg_data[OCNT_W-1:0];
					CFG_RELU_ENABLE:  relu_q         <= cfg_data[0];
					default: ;
				endcase
			end
			if (act_wr) begin
				slot_q <= slot_last ? '0 : slot_q + 1'b1;
			end
			if (w_fire) begin
				if (row_last) begin
					wpos_q   <= '0;
					neuron_q <= layer_last ? '0 : neuron_q + 1'b1;
				end else begin
					wpos_q <= wpos_q + 1'b1;
				end
			end
			// a credit is held from a row end's acceptance until its word leaves
			if ((w_fire && row_last) && !pop) begin
				cred_q <= cred_q + 1'b1;
			end else if (!(w_fire && row_last) && pop) begin
				cred_q <= cred_q - 1'b1;
			end
		end
	end

	dlr_act_mem #(
		.DEPTH (MAX_INPUTS),
		.ADDR_W(ADDR_W)
	) u_mem (
		.clk  (clk),
		.we   (act_wr),
		.waddr(slot_q),
		.wdata(in_word.sample),
		.re   (w_fire),
		.raddr(wpos_q),
		.rdata(act)
	);

	dlr_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.relu_en  (relu_q),
		.issue    (issue),
		.act      (act),
		.push     (push),
		.push_word(push_word)
	);

	dlr_out_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_word(push_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_word)
	);

endmodule
`default_nettype wire
